FILE: design/sspe_pkg.sv
// Package for the sorted set pair engine: action and status codes, queue entry type.
// No dependencies.
`default_nettype none
package sspe_pkg;
   localparam int ValueWidth = 31;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_SHOW   = 2'd1,
      ACT_INTER  = 2'd2,
      ACT_UNION  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_QUERY     = 2'd3
   } status_type;

   typedef struct packed {
      action_type             action;
      logic                   which_set;
      logic [ValueWidth-1:0]  item_value;
   } cmd_type;
endpackage
`default_nettype wire

FILE: design/sorted_set_pair_engine.sv
// Top level of the sorted set pair engine: command queue front end and set back end.
// Depends on sspe_pkg, sspe_front and sspe_back.
//
// Usage: drive req_action, req_which_set and req_item_value with start high; the
// transaction is accepted at an edge where start is high and busy is low. Up to
// two commands wait in the queue in front of the sequencer.
// Results appear one per strobe on the rsp_ ports for a single cycle; the
// receiver cannot stall them. rsp_last marks the final result of a command.
// Operation: an insert scans the entries up to its position and then shifts the
// entries above it up one; a show reads each entry in turn; intersection and union
// scan the second set for every entry of the first, all through the one read port
// of each set memory. Commands run one after another.
// Reset clears both counts and the queue; set contents need no clearing.
`default_nettype none
module sorted_set_pair_engine import sspe_pkg::*; #(
   parameter int SET_CAPACITY = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_which_set,
   input  wire logic [30:0] req_item_value,
   output logic             rsp_strobe,
   output logic [30:0]      rsp_result_value,
   output logic             rsp_has_value,
   output logic             rsp_last,
   output logic [1:0]       rsp_status
);
   cmd_type push_cmd, head_cmd;
   logic    q_full, q_empty, pop;

   assign push_cmd.action     = action_type'(req_action);
   assign push_cmd.which_set  = req_which_set;
   assign push_cmd.item_value = req_item_value;
   assign busy = q_full;

   sspe_front u_front (
      .clock, .reset, .push(start), .push_cmd, .full(q_full),
      .pop, .empty(q_empty), .head_cmd
   );

   sspe_back #(.SET_CAPACITY(SET_CAPACITY)) u_back (
      .clock, .reset, .cmd_valid(!q_empty), .cmd(head_cmd), .cmd_pop(pop),
      .out_strobe(rsp_strobe), .out_value(rsp_result_value),
      .out_has(rsp_has_value), .out_last(rsp_last), .out_status(rsp_status)
   );
endmodule
`default_nettype wire

FILE: design/sspe_front.sv
// Front end of the sorted set pair engine: takes commands into a short queue.
// Depends on sspe_pkg.
`default_nettype none
module sspe_front import sspe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  cmd_type         push_cmd,
   output logic            full,
   input  wire logic       pop,
   output logic            empty,
   output cmd_type         head_cmd
);
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) slot_ff[wr_ptr_ff] <= push_cmd;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && !full) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop && !empty) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push && !full} - {1'b0, pop && !empty};
      end
   end
endmodule
`default_nettype wire

FILE: design/sspe_back.sv
// Back end of the sorted set pair engine: the two set memories and the sequencer.
// Depends on sspe_pkg.
`default_nettype none
module sspe_back import sspe_pkg::*; #(
   parameter int SET_CAPACITY = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   input  cmd_type                    cmd,
   output logic                       cmd_pop,
   output logic                       out_strobe,
   output logic [ValueWidth-1:0]      out_value,
   output logic                       out_has,
   output logic                       out_last,
   output logic [1:0]                 out_status
);
   localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int CW = $clog2(SET_CAPACITY + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_SCAN  = 8'b00000010,  // insert: read entry i, compare
      S_SHIFT = 8'b00000100,  // insert: move entries up one
      S_OUTER = 8'b00001000,  // query: read next entry of the outer set
      S_INNER = 8'b00010000,  // query: scan set two for a match
      S_EMIT  = 8'b00100000,
      S_TAIL  = 8'b01000000,  // union: stream set two; show: stream the chosen set
      S_DONE  = 8'b10000000
   } state_type;

   logic [ValueWidth-1:0] mem0 [SET_CAPACITY];
   logic [ValueWidth-1:0] mem1 [SET_CAPACITY];
   logic [ValueWidth-1:0] rd0_ff, rd1_ff;
   logic [IW-1:0]         ra0, ra1, wa;
   logic                  we, wsel;
   logic [ValueWidth-1:0] wd;

   state_type             state_ff;
   cmd_type               cmd_ff;
   logic [CW-1:0]         cnt0_ff, cnt1_ff;
   logic [CW-1:0]         i_ff, j_ff;
   logic                  rdv_ff, found_ff, any_ff;
   logic [ValueWidth-1:0] hold_ff;
   logic [ValueWidth-1:0] out_value_pend;
   logic [CW-1:0]         n_tail;
   logic [ValueWidth-1:0] tail_rd;
   logic                  idle;

   always_ff @(posedge clock) begin
      if (we && !wsel) mem0[wa] <= wd;
      if (we &&  wsel) mem1[wa] <= wd;
      rd0_ff <= mem0[ra0];
      rd1_ff <= mem1[ra1];
   end

   logic [CW-1:0] n_sel;
   logic [ValueWidth-1:0] rd_sel;
   assign n_sel  = cmd_ff.which_set ? cnt1_ff : cnt0_ff;
   assign rd_sel = cmd_ff.which_set ? rd1_ff : rd0_ff;
   assign idle   = (state_ff == S_IDLE);
   assign cmd_pop = idle && cmd_valid;
   assign n_tail  = (cmd_ff.action == ACT_UNION || cmd_ff.which_set) ? cnt1_ff : cnt0_ff;
   assign tail_rd = (cmd_ff.action == ACT_UNION || cmd_ff.which_set) ? rd1_ff : rd0_ff;

   always_comb begin
      ra0 = i_ff[IW-1:0];
      ra1 = (state_ff == S_INNER || state_ff == S_OUTER) ? j_ff[IW-1:0] : i_ff[IW-1:0];
      if (state_ff == S_SHIFT) begin
         ra0 = IW'(j_ff - CW'(1));
         ra1 = IW'(j_ff - CW'(1));
      end
      we = 1'b0; wsel = cmd_ff.which_set; wa = j_ff[IW-1:0]; wd = rd_sel;
      if (state_ff == S_SHIFT && rdv_ff) begin
         we = 1'b1;
         if (j_ff == i_ff) wd = cmd_ff.item_value;
      end
   end

   always_ff @(posedge clock) begin : seq_blk
      logic strobe_in;
      strobe_in = 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         cnt0_ff  <= '0;
         cnt1_ff  <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd;
                  i_ff   <= '0;
                  j_ff   <= '0;
                  rdv_ff <= 1'b0;
                  any_ff <= 1'b0;
                  found_ff <= 1'b0;
                  unique case (cmd.action)
                     ACT_INSERT: state_ff <= S_SCAN;
                     ACT_SHOW:   state_ff <= S_TAIL;
                     default:    state_ff <= S_OUTER;
                  endcase
               end
            end
            S_SCAN: begin
               // Read entry i, then compare it.
               if (!rdv_ff) begin
                  if (i_ff >= n_sel) begin
                     if (n_sel == CW'(SET_CAPACITY)) begin
                        strobe_in = 1'b1; out_value <= '0; out_has <= 1'b0;
                        out_last <= 1'b1; out_status <= ST_FULL;
                        state_ff <= S_DONE;
                     end else begin
                        j_ff <= n_sel; state_ff <= S_SHIFT;
                     end
                  end else rdv_ff <= 1'b1;
               end else begin
                  rdv_ff <= 1'b0;
                  if (rd_sel == cmd_ff.item_value) begin
                     strobe_in = 1'b1; out_value <= '0; out_has <= 1'b0;
                     out_last <= 1'b1; out_status <= ST_DUPLICATE;
                     state_ff <= S_DONE;
                  end else if (rd_sel > cmd_ff.item_value) begin
                     if (n_sel == CW'(SET_CAPACITY)) begin
                        strobe_in = 1'b1; out_value <= '0; out_has <= 1'b0;
                        out_last <= 1'b1; out_status <= ST_FULL;
                        state_ff <= S_DONE;
                     end else begin
                        j_ff <= n_sel; state_ff <= S_SHIFT;
                     end
                  end else i_ff <= i_ff + CW'(1);
               end
            end
            S_SHIFT: begin
               // Read entry j-1, then write it to j; at j == i write the new value.
               if (!rdv_ff && j_ff != i_ff) rdv_ff <= 1'b1;
               else if (!rdv_ff) rdv_ff <= 1'b1;
               else begin
                  rdv_ff <= 1'b0;
                  if (j_ff == i_ff) begin
                     if (cmd_ff.which_set) cnt1_ff <= cnt1_ff + CW'(1);
                     else cnt0_ff <= cnt0_ff + CW'(1);
                     strobe_in = 1'b1; out_value <= '0; out_has <= 1'b0;
                     out_last <= 1'b1; out_status <= ST_INSERTED;
                     state_ff <= S_DONE;
                  end else j_ff <= j_ff - CW'(1);
               end
            end
            S_OUTER: begin
               if (i_ff >= cnt0_ff) begin
                  if (cmd_ff.action == ACT_UNION) begin
                     i_ff <= '0; rdv_ff <= 1'b0; state_ff <= S_TAIL;
                  end else if (!any_ff) begin
                     strobe_in = 1'b1; out_value <= '0; out_has <= 1'b0;
                     out_last <= 1'b1; out_status <= ST_QUERY;
                     state_ff <= S_DONE;
                  end else state_ff <= S_EMIT;
               end else if (!rdv_ff) rdv_ff <= 1'b1;
               else begin
                  rdv_ff <= 1'b0; j_ff <= '0; found_ff <= 1'b0;
                  hold_ff <= rd0_ff;
                  state_ff <= S_INNER;
               end
            end
            S_INNER: begin
               if (found_ff || j_ff >= cnt1_ff) begin
                  if ((cmd_ff.action == ACT_INTER) == found_ff) begin
                     // Emit the previous pending element; this one becomes pending.
                     if (any_ff) begin
                        strobe_in = 1'b1; out_value <= out_value_pend;
                        out_has <= 1'b1; out_last <= 1'b0; out_status <= ST_QUERY;
                     end
                     any_ff <= 1'b1;
                     out_value_pend <= hold_ff;
                  end
                  i_ff <= i_ff + CW'(1); rdv_ff <= 1'b0;
                  state_ff <= S_OUTER;
               end else if (!rdv_ff) rdv_ff <= 1'b1;
               else begin
                  rdv_ff <= 1'b0;
                  if (rd1_ff == hold_ff) found_ff <= 1'b1;
                  j_ff <= j_ff + CW'(1);
               end
            end
            S_TAIL: begin
               if (i_ff >= n_tail) begin
                  if (!any_ff) begin
                     strobe_in = 1'b1; out_value <= '0; out_has <= 1'b0;
                     out_last <= 1'b1; out_status <= ST_QUERY;
                     state_ff <= S_DONE;
                  end else state_ff <= S_EMIT;
               end else if (!rdv_ff) rdv_ff <= 1'b1;
               else begin
                  rdv_ff <= 1'b0;
                  if (any_ff) begin
                     strobe_in = 1'b1; out_value <= out_value_pend;
                     out_has <= 1'b1; out_last <= 1'b0; out_status <= ST_QUERY;
                  end
                  any_ff <= 1'b1;
                  out_value_pend <= tail_rd;
                  i_ff <= i_ff + CW'(1);
               end
            end
            S_EMIT: begin
               strobe_in = 1'b1; out_value <= out_value_pend; out_has <= 1'b1;
               out_last <= 1'b1; out_status <= ST_QUERY;
               state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
      out_strobe <= strobe_in;
   end
endmodule
`default_nettype wire

FILE: design/sspe_checker.sv
// Port-level checker for the sorted set pair engine, bound to the top level.
// Depends on sspe_pkg and the sorted_set_pair_engine ports.
`default_nettype none
module sspe_checker import sspe_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_strobe,
   input wire logic        rsp_has_value,
   input wire logic        rsp_last,
   input wire logic [1:0]  rsp_status
);
   a_no_value_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_has_value |-> rsp_last) else $error("empty result not last");
   a_insert_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_QUERY |-> !rsp_has_value && rsp_last)
      else $error("insert result malformed");
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe) else $error("strobe right after last");
endmodule

bind sorted_set_pair_engine sspe_checker u_checker (
   .clock, .reset, .rsp_strobe, .rsp_has_value, .rsp_last, .rsp_status
);
`default_nettype wire

FILE: bench/sorted_set_pair_engine_tb.sv
// Self-checking testbench for sorted_set_pair_engine: directed and random command traffic.
// Depends on sspe_pkg and the sorted_set_pair_engine RTL; predicts results with its own set model.
`default_nettype none
module sorted_set_pair_engine_tb;
   import sspe_pkg::*;

   localparam int Capacity = 32;

   typedef struct {
      action_type   action;
      logic         which_set;
      logic [30:0]  item_value;
   } command_type;

   typedef struct {
      logic [30:0]  result_value;
      logic         has_value;
      logic         last;
      status_type   status;
   } result_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic [1:0]   req_action;
   logic         req_which_set;
   logic [30:0]  req_item_value;
   logic         rsp_strobe;
   logic [30:0]  rsp_result_value;
   logic         rsp_has_value;
   logic         rsp_last;
   logic [1:0]   rsp_status;

   sorted_set_pair_engine #(.SET_CAPACITY(Capacity)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_which_set(req_which_set),
      .req_item_value(req_item_value),
      .rsp_strobe(rsp_strobe), .rsp_result_value(rsp_result_value),
      .rsp_has_value(rsp_has_value), .rsp_last(rsp_last), .rsp_status(rsp_status)
   );

   // The predictor keeps its own copy of both sets as sorted queues.
   logic [30:0] set_a[$];
   logic [30:0] set_b[$];
   result_type  expected_results[$];
   command_type pending_commands[$];
   int          error_count = 0;
   bit          stimulus_done = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic bit set_has(ref logic [30:0] s[$], input logic [30:0] v);
      foreach (s[i]) if (s[i] == v) return 1;
      return 0;
   endfunction

   function automatic void push_element(logic [30:0] v);
      result_type r;
      r.result_value = v; r.has_value = 1; r.last = 0; r.status = ST_QUERY;
      expected_results.push_back(r);
   endfunction

   // Applies one command to the set copies and queues the results it must produce.
   function automatic void predict_command(command_type c);
      result_type r;
      int      pos;
      int      before_count;
      before_count = expected_results.size();
      if (c.action == ACT_INSERT) begin
         r.result_value = 0; r.has_value = 0; r.last = 1;
         if (c.which_set ? set_has(set_b, c.item_value) : set_has(set_a, c.item_value))
            r.status = ST_DUPLICATE;
         else if ((c.which_set ? set_b.size() : set_a.size()) >= Capacity)
            r.status = ST_FULL;
         else begin
            r.status = ST_INSERTED;
            pos = 0;
            if (c.which_set) begin
               while (pos < set_b.size() && set_b[pos] < c.item_value) pos++;
               set_b.insert(pos, c.item_value);
            end else begin
               while (pos < set_a.size() && set_a[pos] < c.item_value) pos++;
               set_a.insert(pos, c.item_value);
            end
         end
         expected_results.push_back(r);
         return;
      end
      if (c.action == ACT_SHOW) begin
         if (c.which_set) foreach (set_b[i]) push_element(set_b[i]);
         else foreach (set_a[i]) push_element(set_a[i]);
      end else begin
         foreach (set_a[i])
            if ((c.action == ACT_INTER) == set_has(set_b, set_a[i])) push_element(set_a[i]);
         if (c.action == ACT_UNION) foreach (set_b[i]) push_element(set_b[i]);
      end
      if (expected_results.size() == before_count) begin
         r.result_value = 0; r.has_value = 0; r.last = 1; r.status = ST_QUERY;
         expected_results.push_back(r);
      end else
         expected_results[$].last = 1;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // Driver: waits a random gap before each transaction, then holds start until accepted.
   int gap_left = 0;
   initial begin
      start = 0; req_action = 0; req_which_set = 0; req_item_value = 0;
   end
   always @(posedge clock) begin
      command_type c;
      if (reset) begin
         start <= 0;
      end else if (start && !busy) begin
         // The transaction was accepted at this edge; predict and move on.
         c = pending_commands.pop_front();
         predict_command(c);
         gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 5);
         if (gap_left == 0 && pending_commands.size() > 0) begin
            req_action <= pending_commands[0].action;
            req_which_set <= pending_commands[0].which_set;
            req_item_value <= pending_commands[0].item_value;
         end else
            start <= 0;
      end else if (!start) begin
         if (gap_left > 0)
            gap_left--;
         else if (pending_commands.size() > 0) begin
            start <= 1;
            req_action <= pending_commands[0].action;
            req_which_set <= pending_commands[0].which_set;
            req_item_value <= pending_commands[0].item_value;
         end
      end
   end

   // Monitor: every strobe is one result transaction, checked against the oldest expectation.
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0)
            report_mismatch("result arrived with none expected");
         else begin
            e = expected_results.pop_front();
            if (rsp_result_value !== e.result_value)
               report_mismatch($sformatf("result_value %0d, wanted %0d",
                                         rsp_result_value, e.result_value));
            if (rsp_has_value !== e.has_value)
               report_mismatch($sformatf("has_value %0b, wanted %0b",
                                         rsp_has_value, e.has_value));
            if (rsp_last !== e.last)
               report_mismatch($sformatf("last %0b, wanted %0b", rsp_last, e.last));
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d, wanted %0d", rsp_status, e.status));
         end
      end
   end

   function automatic void add_command(action_type a, logic w, logic [30:0] v);
      command_type c;
      c.action = a; c.which_set = w; c.item_value = v;
      pending_commands.push_back(c);
   endfunction

   // Random values come from a small pool so duplicates and overlaps between
   // the sets are common, with full-range values mixed in.
   function automatic logic [30:0] draw_value();
      if ($urandom_range(0, 3) == 0) return 31'($urandom());
      return 31'($urandom_range(0, 60));
   endfunction

   function automatic action_type draw_action();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return ACT_INSERT;
      if (pick < 7) return ACT_SHOW;
      if (pick < 8) return ACT_INTER;
      return ACT_UNION;
   endfunction

   initial begin
      reset = 1;
      repeat (5) @(posedge clock);
      reset <= 0;
      // Directed part: empty runs on empty sets, value extremes, duplicates,
      // and an overlap between the two sets.
      add_command(ACT_SHOW, 0, 0);
      add_command(ACT_SHOW, 1, 31'h7fffffff);
      add_command(ACT_INTER, 0, 0);
      add_command(ACT_UNION, 1, 0);
      add_command(ACT_INSERT, 0, 31'h7fffffff);
      add_command(ACT_INSERT, 0, 0);
      add_command(ACT_INSERT, 0, 31'h2aaaaaaa);
      add_command(ACT_INSERT, 0, 31'h55555555);
      add_command(ACT_INSERT, 0, 0);
      add_command(ACT_INSERT, 1, 31'h55555555);
      add_command(ACT_INSERT, 1, 7);
      add_command(ACT_INSERT, 1, 31'h7fffffff);
      add_command(ACT_SHOW, 0, 0);
      add_command(ACT_SHOW, 1, 0);
      add_command(ACT_INTER, 1, 31'h7fffffff);
      add_command(ACT_UNION, 0, 0);
      // Fill the first set to capacity, then hit the full and full-duplicate cases.
      for (int i = 0; i < Capacity; i++) add_command(ACT_INSERT, 0, 31'(100 + i));
      add_command(ACT_INSERT, 0, 31'h7fffffff);
      add_command(ACT_INSERT, 0, 5);
      add_command(ACT_UNION, 0, 0);
      wait (pending_commands.size() == 0 && expected_results.size() == 0);
      // Random part: the second set keeps growing, the first is already full.
      for (int i = 0; i < 323; i++)
         add_command(draw_action(), 1'($urandom_range(0, 1)), draw_value());
      for (int i = 0; i < Capacity; i++)
         add_command(ACT_INSERT, 1, 31'(31'h7fffffc0 + i));
      add_command(ACT_INSERT, 1, 1);
      add_command(ACT_UNION, 0, 0);
      add_command(ACT_INTER, 0, 0);
      add_command(ACT_SHOW, 1, 0);
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done && pending_commands.size() == 0 && !start
            && expected_results.size() == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
